// ===== rtl/bmpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpm_pkg
// Shared types and constants for the bmp to monochrome pixel decoder.
// ----------------------------------------------------------------------------
package bmpm_pkg;

  // default sizes of the row buffers and the coordinate width
  localparam int RowBytes24Def = 900;
  localparam int RowBytes1Def  = 64;
  localparam int CoordBitsDef  = 10;

  // bmp header constants
  localparam logic [15:0] BmpSignature = 16'h4D42;
  localparam logic [15:0] Depth24      = 16'd24;
  localparam logic [15:0] Depth1       = 16'd1;
  localparam logic [31:0] MinPixelPos  = 32'd34;

  // luminance weights, threshold applied on the unshifted sum
  localparam logic [7:0]  LumWeightR = 8'd77;
  localparam logic [7:0]  LumWeightG = 8'd150;
  localparam logic [7:0]  LumWeightB = 8'd29;
  localparam logic [15:0] LumWhite   = 16'd32768;

  // configuration register indexes
  localparam logic [1:0] RegScreenWidth  = 2'd0;
  localparam logic [1:0] RegScreenHeight = 2'd1;
  localparam logic [1:0] RegPlaceX       = 2'd2;
  localparam logic [1:0] RegPlaceY       = 2'd3;

  localparam logic [9:0] ScreenWidthRst  = 10'd264;
  localparam logic [9:0] ScreenHeightRst = 10'd176;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_FINISH = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_SIG   = 2'd1,
    ERR_COMP  = 2'd2,
    ERR_DEPTH = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_PIX  = 2'd1,
    PH_DONE = 2'd2,
    PH_PEND = 2'd3
  } phase_e;

  // result slots: 0 pending finish, 1..8 pixel lanes, 9 status
  localparam int NumSlots   = 10;
  localparam int SlotStatus = 9;

  typedef struct packed {
    logic [9:0] screen_width;
    logic [9:0] screen_height;
    logic [9:0] place_x;
    logic [9:0] place_y;
  } cfg_t;

  typedef struct packed {
    logic [NumSlots-1:0] mask;
    kind_e               st_kind;
    err_e                st_err;
    logic [7:0][9:0]     px_x;
    logic [9:0]          px_y;
    logic [7:0]          white;
  } bundle_t;

endpackage

// ===== rtl/bmpm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpm_core
// Header parser and pixel converter: turns one file byte into a result bundle.
// ----------------------------------------------------------------------------
module bmpm_core #(
  parameter int ROW_BYTES_24 = bmpm_pkg::RowBytes24Def,
  parameter int ROW_BYTES_1  = bmpm_pkg::RowBytes1Def,
  parameter int COORD_BITS   = bmpm_pkg::CoordBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        data_byte_i,
  input  logic              start_of_file_i,
  input  bmpm_pkg::cfg_t    cfg_i,
  output bmpm_pkg::bundle_t bundle_o
);

  localparam int I1W = $clog2(ROW_BYTES_1 + 1);
  localparam logic [9:0] CMask = (COORD_BITS >= 10) ? 10'h3FF : 10'((1 << COORD_BITS) - 1);

  bmpm_pkg::phase_e phase_q, phase_d;
  logic [31:0] pos_q, pos_d, offset_q, offset_d, width_q, width_d;
  logic [31:0] height_q, height_d, row_q, row_d;
  logic [15:0] depth_q, depth_d;
  logic        comp_q, comp_d, bottom_up_q, bottom_up_d;
  logic [33:0] rbi_q, rbi_d, rs_q, rs_d;
  logic [1:0]  k3_q, k3_d;
  logic [32:0] col_q, col_d;
  logic [9:0]  ox_q, ox_d, oy_q, oy_d;
  logic [7:0]  blue_q, blue_d, green_q, green_d;

  logic [15:0] lum;
  assign lum = 16'(data_byte_i) * 16'(bmpm_pkg::LumWeightR)
             + 16'(green_q) * 16'(bmpm_pkg::LumWeightG)
             + 16'(blue_q) * 16'(bmpm_pkg::LumWeightB);

  always_comb begin
    logic [31:0] ew;
    logic [31:0] start;
    logic [33:0] y;
    logic [33:0] x;
    logic [32:0] lcol;
    logic        vis;
    logic [33:0] t24;
    logic [32:0] t1;
    logic [5:0]  p6;

    phase_d = phase_q; pos_d = pos_q; offset_d = offset_q; width_d = width_q;
    height_d = height_q; row_d = row_q; depth_d = depth_q; comp_d = comp_q;
    bottom_up_d = bottom_up_q; rbi_d = rbi_q; rs_d = rs_q; k3_d = k3_q; col_d = col_q;
    ox_d = ox_q; oy_d = oy_q; blue_d = blue_q; green_d = green_q;
    bundle_o = '0;
    bundle_o.st_kind = bmpm_pkg::KIND_FINISH;
    bundle_o.st_err  = bmpm_pkg::ERR_NONE;

    if (phase_q == bmpm_pkg::PH_PEND) begin
      bundle_o.mask[0] = 1'b1;
      phase_d = bmpm_pkg::PH_DONE;
    end
    if (start_of_file_i) begin
      pos_d = '0; offset_d = '0; width_d = '0; height_d = '0; depth_d = '0;
      comp_d = 1'b0; bottom_up_d = 1'b1; row_d = '0; rbi_d = '0; k3_d = '0;
      col_d = '0; ox_d = '0; oy_d = '0; blue_d = '0; green_d = '0; rs_d = '0;
      phase_d = bmpm_pkg::PH_HEAD;
    end

    ew = width_d[31] ? 32'd0 : width_d;
    start = (offset_d < bmpm_pkg::MinPixelPos) ? bmpm_pkg::MinPixelPos : offset_d;
    p6 = pos_d[5:0];
    t24 = 34'(ew) + 34'(ew) + 34'(ew) + 34'd3;
    t1 = 33'(ew) + 33'd31;
    y = '0; x = '0; lcol = '0; vis = 1'b0;

    if (phase_d == bmpm_pkg::PH_HEAD) begin
      if (pos_d[31:6] == '0) begin
        case (p6) inside
          6'd0: blue_d = data_byte_i;
          6'd1: begin
            if ({data_byte_i, blue_d} != bmpm_pkg::BmpSignature) begin
              bundle_o.mask[bmpm_pkg::SlotStatus] = 1'b1;
              bundle_o.st_kind = bmpm_pkg::KIND_REJECT;
              bundle_o.st_err  = bmpm_pkg::ERR_SIG;
              phase_d = bmpm_pkg::PH_DONE;
            end
          end
          [6'd10:6'd13]: offset_d[{2'(p6[1:0] - 2'd2), 3'b000} +: 8] = data_byte_i;
          [6'd18:6'd21]: width_d[{2'(p6[1:0] - 2'd2), 3'b000} +: 8] = data_byte_i;
          [6'd22:6'd25]: height_d[{2'(p6[1:0] - 2'd2), 3'b000} +: 8] = data_byte_i;
          6'd28: depth_d[7:0] = data_byte_i;
          6'd29: depth_d[15:8] = data_byte_i;
          [6'd30:6'd33]: begin
            if (data_byte_i != 8'd0) comp_d = 1'b1;
            if (p6 == 6'd33) begin
              if (comp_d) begin
                bundle_o.mask[bmpm_pkg::SlotStatus] = 1'b1;
                bundle_o.st_kind = bmpm_pkg::KIND_REJECT;
                bundle_o.st_err  = bmpm_pkg::ERR_COMP;
                phase_d = bmpm_pkg::PH_DONE;
              end else if (depth_d != bmpm_pkg::Depth24 && depth_d != bmpm_pkg::Depth1) begin
                bundle_o.mask[bmpm_pkg::SlotStatus] = 1'b1;
                bundle_o.st_kind = bmpm_pkg::KIND_REJECT;
                bundle_o.st_err  = bmpm_pkg::ERR_DEPTH;
                phase_d = bmpm_pkg::PH_DONE;
              end else begin
                bottom_up_d = 1'b1;
                if (height_d[31]) begin
                  height_d = 32'(-height_d);
                  bottom_up_d = 1'b0;
                end
                if (cfg_i.place_x == '0 && cfg_i.place_y == '0) begin
                  ox_d = (ew >= 32'(cfg_i.screen_width)) ? 10'd0
                       : 10'((32'(cfg_i.screen_width) - ew) >> 1);
                  oy_d = (height_d >= 32'(cfg_i.screen_height)) ? 10'd0
                       : 10'((32'(cfg_i.screen_height) - height_d) >> 1);
                end else begin
                  ox_d = cfg_i.place_x;
                  oy_d = cfg_i.place_y;
                end
                rs_d = (depth_d == bmpm_pkg::Depth24) ? {t24[33:2], 2'b00}
                                                     : 34'({t1[32:5], 2'b00});
                row_d = '0; rbi_d = '0; k3_d = '0; col_d = '0;
                if (height_d == '0 || rs_d == '0) begin
                  bundle_o.mask[bmpm_pkg::SlotStatus] = 1'b1;
                  bundle_o.st_kind = bmpm_pkg::KIND_FINISH;
                  phase_d = bmpm_pkg::PH_DONE;
                end else begin
                  phase_d = bmpm_pkg::PH_PIX;
                end
              end
            end
          end
          default: ;
        endcase
      end
      if (pos_d != '1) pos_d = pos_d + 32'd1;
    end else if (phase_d == bmpm_pkg::PH_PIX) begin
      if (pos_d >= start) begin
        y = bottom_up_d ? 34'(oy_d) + 34'(height_d) - 34'd1 - 34'(row_d)
                        : 34'(oy_d) + 34'(row_d);
        vis = y < 34'(cfg_i.screen_height);
        bundle_o.px_y = y[9:0] & CMask;
        if (depth_d == bmpm_pkg::Depth24) begin
          case (k3_d)
            2'd0: begin
              blue_d = data_byte_i;
              k3_d = 2'd1;
            end
            2'd1: begin
              green_d = data_byte_i;
              k3_d = 2'd2;
            end
            default: begin
              x = 34'(ox_d) + 34'(col_d);
              if (col_d < 33'(ew) && rbi_d < 34'(ROW_BYTES_24) && vis
                  && x < 34'(cfg_i.screen_width)) begin
                bundle_o.mask[1] = 1'b1;
                bundle_o.px_x[0] = x[9:0] & CMask;
                bundle_o.white[0] = (lum >= bmpm_pkg::LumWhite);
              end
              k3_d = 2'd0;
              col_d = col_d + 33'd1;
            end
          endcase
        end else begin
          if (rbi_d < 34'(ROW_BYTES_1) && vis) begin
            for (int ln = 0; ln < 8; ln++) begin
              lcol = 33'({rbi_d[I1W-1:0], 3'(ln)});
              x = 34'(ox_d) + 34'(lcol);
              if (lcol < 33'(ew) && x < 34'(cfg_i.screen_width)) begin
                bundle_o.mask[ln+1] = 1'b1;
                bundle_o.px_x[ln] = x[9:0] & CMask;
                bundle_o.white[ln] = data_byte_i[7-ln];
              end
            end
          end
        end
        rbi_d = rbi_d + 34'd1;
        if (rbi_d >= rs_d) begin
          rbi_d = '0; k3_d = '0; col_d = '0;
          row_d = row_d + 32'd1;
          if (row_d >= height_d) begin
            if (&bundle_o.mask[8:1]) begin
              phase_d = bmpm_pkg::PH_PEND;
            end else begin
              bundle_o.mask[bmpm_pkg::SlotStatus] = 1'b1;
              bundle_o.st_kind = bmpm_pkg::KIND_FINISH;
              phase_d = bmpm_pkg::PH_DONE;
            end
          end
        end
      end
      if (pos_d != '1) pos_d = pos_d + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bmpm_pkg::PH_HEAD;
      pos_q <= '0; offset_q <= '0; width_q <= '0; height_q <= '0; row_q <= '0;
      depth_q <= '0; comp_q <= 1'b0; bottom_up_q <= 1'b1; rbi_q <= '0; rs_q <= '0;
      k3_q <= '0; col_q <= '0; ox_q <= '0; oy_q <= '0; blue_q <= '0; green_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      pos_q <= pos_d; offset_q <= offset_d; width_q <= width_d; height_q <= height_d;
      row_q <= row_d; depth_q <= depth_d; comp_q <= comp_d; bottom_up_q <= bottom_up_d;
      rbi_q <= rbi_d; rs_q <= rs_d; k3_q <= k3_d; col_q <= col_d; ox_q <= ox_d;
      oy_q <= oy_d; blue_q <= blue_d; green_q <= green_d;
    end
  end

endmodule

// ===== rtl/bmp_to_mono_pixel_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_to_mono_pixel_decoder
// Parses a bmp byte stream and emits monochrome pixel write transactions.
// ----------------------------------------------------------------------------
// usage
// - input channel: one file byte per transaction, start_of_file_i on byte 0
//   restarts parsing and abandons any image in progress
// - output channel: pixel writes, image finished or image rejected, with
//   last_of_item_o on the final result caused by one input byte
// - config port: plain write, index 0 screen width, 1 screen height,
//   2 place x, 3 place y; write only while the block is idle
// - each byte is parsed in the cycle it is accepted and its results land in
//   a bundle register; the first result is visible the next cycle
// - results leave one per cycle from the bundle register while the receiver
//   is ready: one per result a byte causes, up to eight for a 1-bit byte
// - a byte with no results leaves the bundle empty and input stays ready
// - a new byte is taken in the cycle the last result of the previous one is
//   taken, so a stalled receiver simply holds the bundle and stops input
// - reset clears the parser to the header phase and loads the default
//   screen size 264 x 176 with centred placement
// ----------------------------------------------------------------------------
module bmp_to_mono_pixel_decoder #(
  parameter int ROW_BYTES_24 = bmpm_pkg::RowBytes24Def,
  parameter int ROW_BYTES_1  = bmpm_pkg::RowBytes1Def,
  parameter int COORD_BITS   = bmpm_pkg::CoordBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       start_of_file_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [1:0] error_code_o,
  output logic [9:0] pixel_x_o,
  output logic [9:0] pixel_y_o,
  output logic       white_o,
  output logic       last_of_item_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [9:0] cfg_data_i
);

  bmpm_pkg::cfg_t    cfg_q;
  bmpm_pkg::bundle_t bundle_new;
  bmpm_pkg::bundle_t bundle_q;
  logic [bmpm_pkg::NumSlots-1:0] mask_q, mask_d, first;
  logic in_fire, out_fire, is_last;
  logic [3:0] slot;
  logic [2:0] lane;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= bmpm_pkg::ScreenWidthRst;
      cfg_q.screen_height <= bmpm_pkg::ScreenHeightRst;
      cfg_q.place_x       <= '0;
      cfg_q.place_y       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmpm_pkg::RegScreenWidth:  cfg_q.screen_width  <= cfg_data_i;
        bmpm_pkg::RegScreenHeight: cfg_q.screen_height <= cfg_data_i;
        bmpm_pkg::RegPlaceX:       cfg_q.place_x       <= cfg_data_i;
        bmpm_pkg::RegPlaceY:       cfg_q.place_y       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // parser and pixel conversion, state advances on an accepted byte
  bmpm_core #(
    .ROW_BYTES_24(ROW_BYTES_24),
    .ROW_BYTES_1 (ROW_BYTES_1),
    .COORD_BITS  (COORD_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (in_fire),
    .data_byte_i    (data_byte_i),
    .start_of_file_i(start_of_file_i),
    .cfg_i          (cfg_q),
    .bundle_o       (bundle_new)
  );

  // lowest pending slot goes out first
  assign first   = mask_q & (~mask_q + 1'b1);
  assign is_last = (mask_q & ~first) == '0;

  always_comb begin
    slot = '0;
    for (int s = 0; s < bmpm_pkg::NumSlots; s++) begin
      if (first[s]) slot = 4'(s);
    end
  end

  assign lane        = 3'(slot - 4'd1);
  assign out_valid_o = mask_q != '0;
  assign out_fire    = out_valid_o && out_ready_i;
  // take a new byte once the bundle is empty or its last result leaves now
  assign in_ready_o  = !out_valid_o || (out_ready_i && is_last);
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    mask_d = mask_q;
    if (out_fire) mask_d = mask_q & ~first;
    if (in_fire) mask_d = bundle_new.mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  // payload of the bundle, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) bundle_q <= bundle_new;
  end

  // result fields by slot
  always_comb begin
    kind_o       = bmpm_pkg::KIND_PIXEL;
    error_code_o = bmpm_pkg::ERR_NONE;
    pixel_x_o    = '0;
    pixel_y_o    = '0;
    white_o      = 1'b0;
    if (slot == 4'd0) begin
      kind_o = bmpm_pkg::KIND_FINISH;
    end else if (slot == 4'(bmpm_pkg::SlotStatus)) begin
      kind_o       = bundle_q.st_kind;
      error_code_o = bundle_q.st_err;
    end else begin
      pixel_x_o = bundle_q.px_x[lane];
      pixel_y_o = bundle_q.px_y;
      white_o   = bundle_q.white[lane];
    end
  end

  assign last_of_item_o = is_last;

endmodule
